// ===== rtl/gbn_pkg.sv =====
// shared constants, types and codes of the go-back-n receiver
`default_nettype none
package gbn_pkg;

	localparam int SEQ_WIDTH   = 32;
	localparam int COUNT_WIDTH = 32;
	localparam int MAX_PAYLOAD = 2048;
	localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

	typedef enum logic [1:0] {
		PH_RECEIVING = 2'd0,
		PH_LINGER    = 2'd1,
		PH_DONE      = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		ST_DATA_OK     = 4'd0,
		ST_DATA_DUP    = 4'd1,
		ST_DATA_OOO    = 4'd2,
		ST_FIN_OK      = 4'd3,
		ST_FIN_DUP     = 4'd4,
		ST_FIN_OOO     = 4'd5,
		ST_FINAL_ACK   = 4'd6,
		ST_INVALID     = 4'd7,
		ST_IGN_TYPE    = 4'd8,
		ST_IGN_SENDER  = 4'd9,
		ST_IDLE        = 4'd10,
		ST_COMPLETE    = 4'd11,
		ST_DONE        = 4'd12
	} status_t;

	typedef struct packed {
		logic        func;
		logic        format_ok;
		logic        is_data;
		logic        is_fin;
		logic [31:0] seq_num;
		logic [31:0] src_ip;
		logic [15:0] src_port;
		logic [11:0] payload_len;
	} item_t;

	typedef struct packed {
		phase_t                 phase;
		logic                   sender_known;
		logic [31:0]            sender_ip;
		logic [15:0]            sender_port;
		logic [SEQ_WIDTH-1:0]   expected_seq;
	} rx_state_t;

	typedef struct packed {
		status_t          status;
		logic             send_ack;
		logic             write_payload;
		logic             inc_acc;
		logic             inc_dup;
		logic             inc_ooo;
		logic             inc_inv;
		logic             inc_ign;
		logic             lock;
		logic             seq_adv;
		phase_t           phase_nxt;
		logic [LEN_W-1:0] len_clamp;
	} dec_t;

endpackage
`default_nettype wire

// ===== rtl/gbn_ctr.sv =====
// saturating statistics counter, shows the value after the current item
`default_nettype none
module gbn_ctr (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire logic [gbn_pkg::LEN_W-1:0]           inc,
	output logic      [gbn_pkg::COUNT_WIDTH-1:0]     nxt
);

	logic [gbn_pkg::COUNT_WIDTH-1:0] cnt_q;
	logic [gbn_pkg::COUNT_WIDTH:0]   sum;

	assign sum = {1'b0, cnt_q} + (gbn_pkg::COUNT_WIDTH + 1)'(inc);

	always_comb begin
		if (!en) begin
			nxt = cnt_q;
		end else if (sum[gbn_pkg::COUNT_WIDTH]) begin
			nxt = '1;
		end else begin
			nxt = sum[gbn_pkg::COUNT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (en) begin
			cnt_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/gbn_decide.sv =====
// per-item classification of a packet or timeout against the receiver state
`default_nettype none
module gbn_decide (
	input  wire gbn_pkg::item_t     item,
	input  wire gbn_pkg::rx_state_t st,
	output gbn_pkg::dec_t           dec
);

	logic                           same;
	logic [gbn_pkg::SEQ_WIDTH-1:0]  seq;
	logic                           fin_only;

	assign same = st.sender_known && (st.sender_ip == item.src_ip)
		&& (st.sender_port == item.src_port);
	assign seq = item.seq_num[gbn_pkg::SEQ_WIDTH-1:0];
	assign fin_only = !item.is_data;

	always_comb begin
		dec = '0;
		dec.status = gbn_pkg::ST_IDLE;
		dec.phase_nxt = st.phase;
		if (int'(item.payload_len) > gbn_pkg::MAX_PAYLOAD) begin
			dec.len_clamp = gbn_pkg::LEN_W'(gbn_pkg::MAX_PAYLOAD);
		end else begin
			dec.len_clamp = gbn_pkg::LEN_W'(item.payload_len);
		end
		case (st.phase)
			gbn_pkg::PH_DONE: begin
				dec.status = gbn_pkg::ST_DONE;
			end
			gbn_pkg::PH_LINGER: begin
				if (item.func) begin
					dec.phase_nxt = gbn_pkg::PH_DONE;
					dec.status = gbn_pkg::ST_COMPLETE;
				end else if (!same) begin
					dec.inc_ign = 1'b1;
					dec.status = gbn_pkg::ST_IGN_SENDER;
				end else if (!item.format_ok) begin
					dec.inc_inv = 1'b1;
					dec.status = gbn_pkg::ST_INVALID;
				end else if (item.is_data || item.is_fin) begin
					dec.inc_dup = 1'b1;
					dec.send_ack = 1'b1;
					dec.status = gbn_pkg::ST_FINAL_ACK;
				end
			end
			gbn_pkg::PH_RECEIVING: begin
				if (!item.func) begin
					if (!item.format_ok) begin
						dec.inc_inv = 1'b1;
						dec.status = gbn_pkg::ST_INVALID;
					end else if (!item.is_data && !item.is_fin) begin
						dec.inc_ign = 1'b1;
						dec.status = gbn_pkg::ST_IGN_TYPE;
					end else if (st.sender_known && !same) begin
						dec.inc_ign = 1'b1;
						dec.status = gbn_pkg::ST_IGN_SENDER;
					end else begin
						dec.lock = !st.sender_known;
						dec.send_ack = 1'b1;
						if (seq == st.expected_seq) begin
							dec.seq_adv = 1'b1;
							if (fin_only) begin
								dec.status = gbn_pkg::ST_FIN_OK;
								dec.phase_nxt = gbn_pkg::PH_LINGER;
							end else begin
								dec.status = gbn_pkg::ST_DATA_OK;
								dec.write_payload = 1'b1;
								dec.inc_acc = 1'b1;
							end
						end else if (seq < st.expected_seq) begin
							dec.inc_dup = 1'b1;
							dec.status = fin_only ? gbn_pkg::ST_FIN_DUP
								: gbn_pkg::ST_DATA_DUP;
						end else begin
							dec.inc_ooo = 1'b1;
							dec.status = fin_only ? gbn_pkg::ST_FIN_OOO
								: gbn_pkg::ST_DATA_OOO;
						end
					end
				end
			end
			default: begin
				dec.status = gbn_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/go_back_n_packet_receiver_unit.sv =====
// go-back-n receiver: an accepted item passes the input register, then the result register
// throughput one item per cycle while out_ready is high; input register, decision logic, result register
// receiver state and counters update as an item moves into the result register
// asynchronous active-low reset: phase receiving, no sender, expected seq 0,
// all counters 0, both pipeline registers empty
`default_nettype none
module go_back_n_packet_receiver_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        func,
	input  wire logic        format_ok,
	input  wire logic        is_data,
	input  wire logic        is_fin,
	input  wire logic [31:0] seq_num,
	input  wire logic [31:0] src_ip,
	input  wire logic [15:0] src_port,
	input  wire logic [11:0] payload_len,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       status,
	output logic             send_ack,
	output logic [31:0]      ack_number,
	output logic             write_payload,
	output logic [31:0]      accepted_count,
	output logic [31:0]      duplicate_count,
	output logic [31:0]      out_of_order_count,
	output logic [31:0]      invalid_count,
	output logic [31:0]      ignored_count,
	output logic [31:0]      ack_count,
	output logic [31:0]      byte_count,
	output logic             done_res
);

	localparam int CW = gbn_pkg::COUNT_WIDTH;
	localparam int LW = gbn_pkg::LEN_W;

	logic              valid_s1;
	gbn_pkg::item_t    item_s1;
	logic              valid_s2;
	logic              adv;

	gbn_pkg::rx_state_t st_q;
	gbn_pkg::dec_t      dec;
	logic [gbn_pkg::SEQ_WIDTH-1:0] seq_nxt;

	logic [CW-1:0] acc_nxt, dup_nxt, ooo_nxt, inv_nxt, ign_nxt, ackc_nxt, byte_nxt;

	logic [3:0]  status_s2;
	logic        send_ack_s2;
	logic [31:0] ack_number_s2;
	logic        write_s2;
	logic [31:0] acc_s2, dup_s2, ooo_s2, inv_s2, ign_s2, ackc_s2, byte_s2;
	logic        done_s2;

	assign adv = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{func: func, format_ok: format_ok, is_data: is_data,
				is_fin: is_fin, seq_num: seq_num, src_ip: src_ip,
				src_port: src_port, payload_len: payload_len};
		end
	end

	gbn_decide u_decide (
		.item (item_s1),
		.st   (st_q),
		.dec  (dec)
	);

	assign seq_nxt = dec.seq_adv ? st_q.expected_seq + 1'b1 : st_q.expected_seq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: gbn_pkg::PH_RECEIVING, sender_known: 1'b0,
				sender_ip: '0, sender_port: '0, expected_seq: '0};
		end else if (adv) begin
			st_q.phase <= dec.phase_nxt;
			st_q.expected_seq <= seq_nxt;
			if (dec.lock) begin
				st_q.sender_known <= 1'b1;
				st_q.sender_ip <= item_s1.src_ip;
				st_q.sender_port <= item_s1.src_port;
			end
		end
	end

	gbn_ctr u_acc (.clk(clk), .arst_n(arst_n), .en(adv && dec.inc_acc),
		.inc(LW'(1)), .nxt(acc_nxt));
	gbn_ctr u_dup (.clk(clk), .arst_n(arst_n), .en(adv && dec.inc_dup),
		.inc(LW'(1)), .nxt(dup_nxt));
	gbn_ctr u_ooo (.clk(clk), .arst_n(arst_n), .en(adv && dec.inc_ooo),
		.inc(LW'(1)), .nxt(ooo_nxt));
	gbn_ctr u_inv (.clk(clk), .arst_n(arst_n), .en(adv && dec.inc_inv),
		.inc(LW'(1)), .nxt(inv_nxt));
	gbn_ctr u_ign (.clk(clk), .arst_n(arst_n), .en(adv && dec.inc_ign),
		.inc(LW'(1)), .nxt(ign_nxt));
	gbn_ctr u_ackc (.clk(clk), .arst_n(arst_n), .en(adv && dec.send_ack),
		.inc(LW'(1)), .nxt(ackc_nxt));
	gbn_ctr u_byte (.clk(clk), .arst_n(arst_n), .en(adv && dec.inc_acc),
		.inc(dec.len_clamp), .nxt(byte_nxt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2     <= dec.status;
			send_ack_s2   <= dec.send_ack;
			ack_number_s2 <= 32'(seq_nxt);
			write_s2      <= dec.write_payload;
			acc_s2        <= 32'(acc_nxt);
			dup_s2        <= 32'(dup_nxt);
			ooo_s2        <= 32'(ooo_nxt);
			inv_s2        <= 32'(inv_nxt);
			ign_s2        <= 32'(ign_nxt);
			ackc_s2       <= 32'(ackc_nxt);
			byte_s2       <= 32'(byte_nxt);
			done_s2       <= (dec.phase_nxt == gbn_pkg::PH_DONE);
		end
	end

	assign out_valid          = valid_s2;
	assign status             = status_s2;
	assign send_ack           = send_ack_s2;
	assign ack_number         = ack_number_s2;
	assign write_payload      = write_s2;
	assign accepted_count     = acc_s2;
	assign duplicate_count    = dup_s2;
	assign out_of_order_count = ooo_s2;
	assign invalid_count      = inv_s2;
	assign ignored_count      = ign_s2;
	assign ack_count          = ackc_s2;
	assign byte_count         = byte_s2;
	assign done_res           = done_s2;

`ifndef SYNTHESIS
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == gbn_pkg::PH_DONE |=> st_q.phase == gbn_pkg::PH_DONE)
		else $error("done phase left");

	a_done_status: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && done_s2) |-> (status_s2 == gbn_pkg::ST_COMPLETE
		|| status_s2 == gbn_pkg::ST_DONE))
		else $error("done result with wrong status");

	a_write_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && write_s2) |-> (send_ack_s2
		&& status_s2 == gbn_pkg::ST_DATA_OK))
		else $error("payload write without in-order data ack");

	a_lock_once: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.sender_known |=> (st_q.sender_known && $stable(st_q.sender_ip)
		&& $stable(st_q.sender_port)))
		else $error("sender lock changed");
`endif

endmodule
`default_nettype wire
